### rtl/ofdm_qam_subcarrier_mapper_macros.svh
// Assertion helpers shared by the mapper RTL.
`ifndef OFDM_QAM_SUBCARRIER_MAPPER_MACROS_SVH
`define OFDM_QAM_SUBCARRIER_MAPPER_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define OQM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition implies a consequence in the next cycle.
`define OQM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`else

`define OQM_ASSERT(label, clk, rst_n, prop)
`define OQM_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

### rtl/oqm_pkg.sv
`default_nettype none

package oqm_pkg;

  localparam int FRACTION_BITS_DEF = 13;
  localparam int QUEUE_DEPTH_DEF   = 2;
  localparam int SCALE_SHIFT       = 30;

  // Register map indexes
  localparam logic REG_MODULATION = 1'b0;
  localparam logic REG_LAYOUT     = 1'b1;

  typedef enum logic [1:0] {
    MOD_BPSK  = 2'd0,
    MOD_QPSK  = 2'd1,
    MOD_QAM16 = 2'd2,
    MOD_QAM64 = 2'd3
  } mod_e;

  typedef enum logic [1:0] {
    LAYOUT_LEGACY20 = 2'd0,
    LAYOUT_HT20     = 2'd1,
    LAYOUT_HT40     = 2'd2
  } layout_e;

  typedef struct packed {
    logic [1:0] modulation;
    logic [1:0] layout;
  } cfg_t;

  // One classified carrier between front and back
  typedef struct packed {
    logic [5:0] sym;
    logic [1:0] modulation;
    logic [1:0] layout;
    logic [6:0] pos;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [6:0]  bin_index;
    logic [15:0] in_phase;
    logic [15:0] quadrature;
    logic        symbol_last;
  } result_t;

  typedef logic [15:0] level_tab_t [0:31];

  localparam logic [6:0] CARRIERS [0:3] = '{7'd48, 7'd52, 7'd108, 7'd48};

  // Runs of data carriers per layout (first bin, length); row 3 unused
  localparam logic [6:0] RUN_FIRST [0:3][0:7] = '{
    '{7'd6, 7'd12, 7'd26, 7'd33, 7'd40, 7'd54, 7'd0, 7'd0},
    '{7'd4, 7'd12, 7'd26, 7'd33, 7'd40, 7'd54, 7'd0, 7'd0},
    '{7'd6, 7'd12, 7'd40, 7'd54, 7'd66, 7'd76, 7'd90, 7'd118},
    '{7'd6, 7'd12, 7'd26, 7'd33, 7'd40, 7'd54, 7'd0, 7'd0}
  };
  localparam logic [6:0] RUN_LEN [0:3][0:7] = '{
    '{7'd5, 7'd13, 7'd6, 7'd6, 7'd13, 7'd5, 7'd0, 7'd0},
    '{7'd7, 7'd13, 7'd6, 7'd6, 7'd13, 7'd7, 7'd0, 7'd0},
    '{7'd5, 7'd27, 7'd13, 7'd9, 7'd9, 7'd13, 7'd27, 7'd5},
    '{7'd5, 7'd13, 7'd6, 7'd6, 7'd13, 7'd5, 7'd0, 7'd0}
  };

  localparam int LEVEL_LUT [0:3][0:7] = '{
    '{-1, 1, 0, 0, 0, 0, 0, 0},
    '{-1, 1, 0, 0, 0, 0, 0, 0},
    '{-3, -1, 3, 1, 0, 0, 0, 0},
    '{-7, -5, -1, -3, 7, 5, 1, 3}
  };

  // Unsigned Q34.30 scale factors: 1, 1/sqrt2, 1/sqrt10, 1/sqrt42
  localparam logic [63:0] SCALE_Q30 [0:3] = '{
    64'd1073741824, 64'd759250125, 64'd339546978, 64'd165681960
  };

  // Group size mask per modulation: 1, 2, 4 or 6 bits
  function automatic logic [5:0] group_mask(logic [1:0] modulation);
    logic [5:0] m;
    case (modulation)
      MOD_BPSK:  m = 6'b000001;
      MOD_QPSK:  m = 6'b000011;
      MOD_QAM16: m = 6'b001111;
      default:   m = 6'b111111;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] group_size(logic [1:0] modulation);
    logic [2:0] n;
    case (modulation)
      MOD_BPSK:  n = 3'd1;
      MOD_QPSK:  n = 3'd2;
      MOD_QAM16: n = 3'd4;
      default:   n = 3'd6;
    endcase
    return n;
  endfunction

  // Bin of a carrier position: run starts depend on the layout only, so the
  // position is compared against every run in parallel and offset once
  function automatic logic [6:0] carrier_bin(logic [1:0] layout, logic [6:0] pos);
    logic [6:0] start;
    logic [6:0] bin;
    start = '0;
    bin   = '0;
    for (int k = 0; k < 8; k++) begin
      if (pos >= start && pos < start + RUN_LEN[layout][k]) begin
        bin = RUN_FIRST[layout][k] + (pos - start);
      end
      start = start + RUN_LEN[layout][k];
    end
    return bin;
  endfunction

  // Scaled, rounded, saturated levels for every modulation and level code
  function automatic level_tab_t build_levels(int frac);
    level_tab_t  tab;
    logic [63:0] mag;
    logic [63:0] r;
    logic [63:0] neg;
    int          shift;
    int          lvl;
    int          m;
    int          i;
    shift = SCALE_SHIFT - frac;
    for (m = 0; m < 4; m++) begin
      for (i = 0; i < 8; i++) begin
        lvl = LEVEL_LUT[m][i];
        mag = 64'(lvl < 0 ? -lvl : lvl) * SCALE_Q30[m];
        r   = (mag + (64'd1 << (shift - 1))) >> shift;
        if (lvl < 0) begin
          if (r > 64'd32768) r = 64'd32768;
          neg = 64'd0 - r;
          tab[m * 8 + i] = neg[15:0];
        end else begin
          if (r > 64'd32767) r = 64'd32767;
          tab[m * 8 + i] = r[15:0];
        end
      end
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

### rtl/oqm_fifo.sv
`default_nettype none

`include "ofdm_qam_subcarrier_mapper_macros.svh"

module oqm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `OQM_ASSERT(a_fifo_count_range, clk_i, rst_ni, count_q <= CNT_W'(DEPTH))
  `OQM_ASSERT_NEXT(a_fifo_fill, clk_i, rst_ni, do_push && !do_pop,
    count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

### rtl/oqm_front.sv
`default_nettype none

`include "ofdm_qam_subcarrier_mapper_macros.svh"

module oqm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire oqm_pkg::cfg_t cfg_i,
  input  wire logic          accept_i,
  input  wire logic          coded_bit_i,
  output logic               push_o,
  output oqm_pkg::item_t     item_o
);

  logic [5:0] gather_q, gather_d;
  logic [2:0] held_q, held_d;
  logic [6:0] count_q, count_d;
  logic [5:0] gather_nxt;
  logic [2:0] held_nxt;
  logic [1:0] layout;
  logic [6:0] total;
  logic [6:0] pos;
  logic       last;
  logic       complete;

  // Layout code 3 falls back to legacy 20 MHz
  assign layout = (cfg_i.layout == oqm_pkg::LAYOUT_HT20 ||
                   cfg_i.layout == oqm_pkg::LAYOUT_HT40) ? cfg_i.layout
                                                         : oqm_pkg::LAYOUT_LEGACY20;
  assign total  = oqm_pkg::CARRIERS[layout];

  // Shift in the bit and check for a full group
  assign gather_nxt = {gather_q[4:0], coded_bit_i};
  assign held_nxt   = held_q + 3'd1;
  assign complete   = (held_nxt >= oqm_pkg::group_size(cfg_i.modulation));

  // Carrier position restarts if it ran past the layout
  assign pos  = (count_q >= total) ? 7'd0 : count_q;
  assign last = ((8'(pos) + 8'd1) >= 8'(total));

  assign push_o            = accept_i && complete;
  assign item_o.sym        = gather_nxt & oqm_pkg::group_mask(cfg_i.modulation);
  assign item_o.modulation = cfg_i.modulation;
  assign item_o.layout     = layout;
  assign item_o.pos        = pos;
  assign item_o.last       = last;

  always_comb begin
    gather_d = gather_q;
    held_d   = held_q;
    count_d  = count_q;
    if (accept_i) begin
      if (complete) begin
        gather_d = '0;
        held_d   = '0;
        count_d  = last ? 7'd0 : pos + 7'd1;
      end else begin
        gather_d = gather_nxt;
        held_d   = held_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_q <= '0;
      held_q   <= '0;
      count_q  <= '0;
    end else begin
      gather_q <= gather_d;
      held_q   <= held_d;
      count_q  <= count_d;
    end
  end

  `OQM_ASSERT(a_held_range, clk_i, rst_ni, held_q <= 3'd6)
  `OQM_ASSERT_NEXT(a_group_clears, clk_i, rst_ni, push_o, held_q == 3'd0)
  `OQM_ASSERT_NEXT(a_bit_counted, clk_i, rst_ni, accept_i && !complete,
    held_q == $past(held_q) + 3'd1)

endmodule

`default_nettype wire

### rtl/oqm_back.sv
`default_nettype none

module oqm_back #(
  parameter int FRACTION_BITS = oqm_pkg::FRACTION_BITS_DEF
) (
  input  wire oqm_pkg::item_t item_i,
  output oqm_pkg::result_t    result_o
);

  localparam oqm_pkg::level_tab_t LEVELS = oqm_pkg::build_levels(FRACTION_BITS);

  logic [2:0] i_code;
  logic [2:0] q_code;

  // Split the group: upper half to I, lower half to Q; BPSK puts its single bit on I
  always_comb begin
    case (item_i.modulation)
      oqm_pkg::MOD_BPSK: begin
        i_code = {2'b00, item_i.sym[0]};
        q_code = 3'd0;
      end
      oqm_pkg::MOD_QPSK: begin
        i_code = {2'b00, item_i.sym[1]};
        q_code = {2'b00, item_i.sym[0]};
      end
      oqm_pkg::MOD_QAM16: begin
        i_code = {1'b0, item_i.sym[3:2]};
        q_code = {1'b0, item_i.sym[1:0]};
      end
      default: begin
        i_code = item_i.sym[5:3];
        q_code = item_i.sym[2:0];
      end
    endcase
  end

  // Level lookup and bin placement
  assign result_o.bin_index   = oqm_pkg::carrier_bin(item_i.layout, item_i.pos);
  assign result_o.in_phase    = LEVELS[{item_i.modulation, i_code}];
  assign result_o.quadrature  = (item_i.modulation == oqm_pkg::MOD_BPSK) ? 16'd0
                                : LEVELS[{item_i.modulation, q_code}];
  assign result_o.symbol_last = item_i.last;

endmodule

`default_nettype wire

### rtl/ofdm_qam_subcarrier_mapper.sv
// Path: the carrier of a completed group reaches the outputs through the mid queue,
//   then the output queue, after the edge that takes its last bit.
// Throughput: one coded bit per cycle while the mid queue is not full, one carrier per 1, 2,
//   4 or 6 bits; set by the front bit shifter, with queues before and after the level lookup.
// Reset: rst_ni low clears the gatherer, carrier count, queues and registers
//   (BPSK, legacy 20 MHz).
`default_nettype none

module ofdm_qam_subcarrier_mapper #(
  parameter int FRACTION_BITS = oqm_pkg::FRACTION_BITS_DEF,
  parameter int QUEUE_DEPTH   = oqm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // bit input
  input  wire logic        push,
  output logic             full,
  input  wire logic        coded_bit_i,
  // carrier output
  output logic             empty,
  input  wire logic        pop,
  output logic [6:0]       bin_index_o,
  output logic [15:0]      in_phase_o,
  output logic [15:0]      quadrature_o,
  output logic             symbol_last_o
);

  logic [1:0]       modulation_q, modulation_d;
  logic [1:0]       layout_q, layout_d;
  logic             cfg_wr;
  oqm_pkg::cfg_t    cfg;
  logic             accept;
  logic             mid_push, mid_full, mid_empty, mid_pop;
  oqm_pkg::item_t   mid_in, mid_out;
  logic             out_full;
  oqm_pkg::result_t res_in, res_out;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    modulation_d = modulation_q;
    layout_d     = layout_q;
    if (cfg_wr) begin
      case (paddr[2])
        oqm_pkg::REG_MODULATION: modulation_d = pwdata[1:0];
        default:                 layout_d     = pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      oqm_pkg::REG_MODULATION: prdata = {30'd0, modulation_q};
      default:                 prdata = {30'd0, layout_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulation_q <= oqm_pkg::MOD_BPSK;
      layout_q     <= oqm_pkg::LAYOUT_LEGACY20;
    end else begin
      modulation_q <= modulation_d;
      layout_q     <= layout_d;
    end
  end

  assign cfg.modulation = modulation_q;
  assign cfg.layout     = layout_q;

  // Front: gather bits into groups
  assign full   = mid_full;
  assign accept = push && !mid_full;

  oqm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .coded_bit_i (coded_bit_i),
    .push_o      (mid_push),
    .item_o      (mid_in)
  );

  oqm_fifo #(
    .WIDTH ($bits(oqm_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  // Back: levels and bin, one carrier per transfer into the output queue
  assign mid_pop = !mid_empty && !out_full;

  oqm_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .item_i   (mid_out),
    .result_o (res_in)
  );

  oqm_fifo #(
    .WIDTH ($bits(oqm_pkg::result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_pop),
    .data_i  (res_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign bin_index_o   = res_out.bin_index;
  assign in_phase_o    = res_out.in_phase;
  assign quadrature_o  = res_out.quadrature;
  assign symbol_last_o = res_out.symbol_last;

endmodule

`default_nettype wire

### tb/sv/tb_ofdm_qam_subcarrier_mapper.sv
`default_nettype none

module tb_ofdm_qam_subcarrier_mapper;

  localparam int FRAC_BITS     = 13;
  // Carrier passes through the mid and output queues; allow margin after draining
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 200;

  // Data-carrier runs per layout: first FFT bin and run length
  localparam int DATA_RUN_START [0:2][0:7] = '{
    '{6, 12, 26, 33, 40, 54, 0, 0},
    '{4, 12, 26, 33, 40, 54, 0, 0},
    '{6, 12, 40, 54, 66, 76, 90, 118}
  };
  localparam int DATA_RUN_LEN [0:2][0:7] = '{
    '{5, 13, 6, 6, 13, 5, 0, 0},
    '{7, 13, 6, 6, 13, 7, 0, 0},
    '{5, 27, 13, 9, 9, 13, 27, 5}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        push;
  logic        full;
  logic        coded_bit_i;
  logic        empty;
  logic        pop;
  logic [6:0]  bin_index_o;
  logic [15:0] in_phase_o;
  logic [15:0] quadrature_o;
  logic        symbol_last_o;

  // Mapper state mirrored by the predictor
  logic [1:0]  cur_mod;
  logic [1:0]  cur_layout;
  logic [5:0]  gathered_bits;
  logic [2:0]  gathered_count;
  int          carrier_pos;

  oqm_pkg::result_t carrier_q [$];
  int          errors;
  int          bits_sent;
  int          carriers_checked;
  int          symbols_closed;
  int          hold_req;
  bit          tx_idle_en;
  bit          rx_idle_en;

  ofdm_qam_subcarrier_mapper uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .push         (push),
    .full         (full),
    .coded_bit_i  (coded_bit_i),
    .empty        (empty),
    .pop          (pop),
    .bin_index_o  (bin_index_o),
    .in_phase_o   (in_phase_o),
    .quadrature_o (quadrature_o),
    .symbol_last_o(symbol_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gray level for a code of the given modulation
  function automatic int gray_level(logic [1:0] m, logic [2:0] code);
    int lvl;
    case (m)
      oqm_pkg::MOD_BPSK, oqm_pkg::MOD_QPSK: lvl = code[0] ? 1 : -1;
      oqm_pkg::MOD_QAM16: begin
        case (code[1:0])
          2'd0:    lvl = -3;
          2'd1:    lvl = -1;
          2'd2:    lvl = 3;
          default: lvl = 1;
        endcase
      end
      default: begin
        case (code)
          3'd0:    lvl = -7;
          3'd1:    lvl = -5;
          3'd2:    lvl = -1;
          3'd3:    lvl = -3;
          3'd4:    lvl = 7;
          3'd5:    lvl = 5;
          3'd6:    lvl = 1;
          default: lvl = 3;
        endcase
      end
    endcase
    return lvl;
  endfunction

  // Level times 1/sqrt(norm) in Q2.13, rounded half away from zero, saturated
  function automatic logic [15:0] scaled_level(int lvl, logic [1:0] m);
    longint unsigned norm_q30;
    longint unsigned mag;
    longint unsigned r;
    int              shift;
    case (m)
      oqm_pkg::MOD_BPSK:  norm_q30 = 64'd1073741824;
      oqm_pkg::MOD_QPSK:  norm_q30 = 64'd759250125;
      oqm_pkg::MOD_QAM16: norm_q30 = 64'd339546978;
      default:            norm_q30 = 64'd165681960;
    endcase
    shift = 30 - FRAC_BITS;
    mag   = longint'(lvl < 0 ? -lvl : lvl) * norm_q30;
    r     = (mag + (64'd1 << (shift - 1))) >> shift;
    if (lvl < 0) begin
      if (r > 64'd32768) r = 64'd32768;
      r = 64'd0 - r;
    end else if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

  function automatic logic [6:0] fft_bin(int lay, int pos);
    int p;
    p = pos;
    for (int k = 0; k < 8; k++) begin
      if (p < DATA_RUN_LEN[lay][k]) return 7'(DATA_RUN_START[lay][k] + p);
      p -= DATA_RUN_LEN[lay][k];
    end
    return 7'd0;
  endfunction

  // Shift one coded bit in; returns 1 with the carrier when a group completes
  function automatic bit map_coded_bit(input logic b, output oqm_pkg::result_t c);
    int         nbits;
    int         half;
    int         lay;
    int         total;
    logic [5:0] sym;
    logic [5:0] i_code;
    logic [5:0] q_code;
    case (cur_mod)
      oqm_pkg::MOD_BPSK:  nbits = 1;
      oqm_pkg::MOD_QPSK:  nbits = 2;
      oqm_pkg::MOD_QAM16: nbits = 4;
      default:            nbits = 6;
    endcase
    gathered_bits  = {gathered_bits[4:0], b};
    gathered_count = gathered_count + 3'd1;
    c = '0;
    if (gathered_count < nbits) return 1'b0;
    sym = gathered_bits & ((6'd1 << nbits) - 6'd1);
    gathered_bits  = '0;
    gathered_count = '0;
    // unused layout code falls back to legacy 20 MHz
    lay   = (cur_layout > oqm_pkg::LAYOUT_HT40) ? int'(oqm_pkg::LAYOUT_LEGACY20)
                                                : int'(cur_layout);
    total = (lay == oqm_pkg::LAYOUT_HT40) ? 108 : ((lay == oqm_pkg::LAYOUT_HT20) ? 52 : 48);
    // position left over from a wider layout restarts the symbol
    if (carrier_pos >= total) carrier_pos = 0;
    c.bin_index = fft_bin(lay, carrier_pos);
    if (cur_mod == oqm_pkg::MOD_BPSK) begin
      c.in_phase   = scaled_level(gray_level(cur_mod, 3'(sym[0])), cur_mod);
      c.quadrature = '0;
    end else begin
      half   = nbits / 2;
      i_code = sym >> half;
      q_code = sym & ((6'd1 << half) - 6'd1);
      c.in_phase   = scaled_level(gray_level(cur_mod, i_code[2:0]), cur_mod);
      c.quadrature = scaled_level(gray_level(cur_mod, q_code[2:0]), cur_mod);
    end
    if (carrier_pos + 1 >= total) begin
      c.symbol_last = 1'b1;
      carrier_pos   = 0;
    end else begin
      c.symbol_last = 1'b0;
      carrier_pos++;
    end
    return 1'b1;
  endfunction

  task automatic report_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  // Scoreboard: check output transfers, predict from input transfers
  always @(posedge clk_i) begin
    oqm_pkg::result_t want;
    oqm_pkg::result_t pred;
    if (rst_ni && pop && !empty) begin
      if (carrier_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected carrier, expected none, got bin %h I %h Q %h last %b",
                 $time, bin_index_o, in_phase_o, quadrature_o, symbol_last_o);
      end else begin
        want = carrier_q.pop_front();
        report_field("bin_index", 16'(want.bin_index), 16'(bin_index_o));
        report_field("in_phase", want.in_phase, in_phase_o);
        report_field("quadrature", want.quadrature, quadrature_o);
        report_field("symbol_last", 16'(want.symbol_last), 16'(symbol_last_o));
        carriers_checked++;
        if (symbol_last_o) symbols_closed++;
      end
    end
    if (rst_ni && push && !full) begin
      if (map_coded_bit(coded_bit_i, pred)) carrier_q.push_back(pred);
    end
  end

  // Output side: random stall bursts plus requested long hold-offs
  initial begin : pop_driver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (!rst_ni) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb_ofdm_qam_subcarrier_mapper: done, errors");
        $finish;
      end
    end
  end

  // One coded bit, with an occasional idle burst in front
  task automatic send_bit(input logic b);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    push        <= 1'b1;
    coded_bit_i <= b;
    do @(posedge clk_i); while (full);
    bits_sent++;
  endtask

  task automatic send_group(input logic [5:0] value, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) send_bit(value[i]);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_bit(1'($urandom_range(0, 1)));
  endtask

  // Stop sending and wait for every predicted carrier to come out
  task automatic drain;
    push <= 1'b0;
    while (carrier_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write then read-back, only with the mapper idle
  task automatic set_reg(input logic idx, input logic [1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == oqm_pkg::REG_MODULATION) cur_mod = value;
    else cur_layout = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value)) begin
      errors++;
      $display("%0t: register %0d read-back mismatch, expected %h, got %h",
               $time, idx, 32'(value), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Directed levels of both signs for every modulation on the HT 20 MHz layout
  task automatic test_directed_levels;
    set_reg(oqm_pkg::REG_LAYOUT, oqm_pkg::LAYOUT_HT20);
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_BPSK);
    send_group(6'b0, 1);
    send_group(6'b1, 1);
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_QPSK);
    send_group(6'b01, 2);
    send_group(6'b10, 2);
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_QAM16);
    send_group(6'b1000, 4);
    send_group(6'b0111, 4);
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_QAM64);
    send_group(6'b100000, 6);
    send_group(6'b011111, 6);
  endtask

  // Layout code 3 must map like legacy 20 MHz over a whole symbol
  task automatic test_unused_layout;
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_BPSK);
    set_reg(oqm_pkg::REG_LAYOUT, 2'd3);
    send_random(60);
  endtask

  // Modulation switched with a partial group held
  task automatic test_partial_group_switch;
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_QAM64);
    send_random(5);
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_BPSK);
    send_random(1);
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_QAM16);
    send_random(3);
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_QPSK);
    send_random(3);
  endtask

  // Narrower layout selected while deep into an HT 40 MHz symbol
  task automatic test_layout_switch_mid_symbol;
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_BPSK);
    set_reg(oqm_pkg::REG_LAYOUT, oqm_pkg::LAYOUT_HT40);
    send_random(100);
    set_reg(oqm_pkg::REG_LAYOUT, oqm_pkg::LAYOUT_LEGACY20);
    send_random(12);
  endtask

  // Long output hold-off so the queues fill, then a full sender pause
  task automatic test_backpressure;
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_BPSK);
    tx_idle_en = 1'b0;
    hold_req   = HOLD_CYCLES;
    send_random(40);
    drain();
    tx_idle_en = 1'b1;
    send_random(30);
  endtask

  // Random settings per phase, extremes pinned in the first phases
  task automatic test_random_settings;
    logic [1:0] m;
    logic [1:0] l;
    int         count;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin m = oqm_pkg::MOD_BPSK;  l = oqm_pkg::LAYOUT_HT40;     count = 230; end
        1: begin m = oqm_pkg::MOD_QAM64; l = oqm_pkg::LAYOUT_LEGACY20; count = 300; end
        2: begin m = oqm_pkg::MOD_QPSK;  l = 2'd3;                     count = 100; end
        default: begin
          m     = 2'($urandom_range(0, 3));
          l     = 2'($urandom_range(0, 3));
          count = $urandom_range(20, 70);
        end
      endcase
      set_reg(oqm_pkg::REG_MODULATION, m);
      set_reg(oqm_pkg::REG_LAYOUT, l);
      send_random(count);
    end
  endtask

  // Back-to-back transfers on both sides
  task automatic test_streaming;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_QAM16);
    set_reg(oqm_pkg::REG_LAYOUT, oqm_pkg::LAYOUT_HT20);
    send_random(120);
    set_reg(oqm_pkg::REG_MODULATION, oqm_pkg::MOD_BPSK);
    send_random(80);
  endtask

  initial begin
    errors           = 0;
    bits_sent        = 0;
    carriers_checked = 0;
    symbols_closed   = 0;
    hold_req         = 0;
    cur_mod          = oqm_pkg::MOD_BPSK;
    cur_layout       = oqm_pkg::LAYOUT_LEGACY20;
    gathered_bits    = '0;
    gathered_count   = '0;
    carrier_pos      = 0;
    tx_idle_en       = 1'b1;
    rx_idle_en       = 1'b1;
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    push        <= 1'b0;
    coded_bit_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_levels();
    test_unused_layout();
    test_partial_group_switch();
    test_layout_switch_mid_symbol();
    test_backpressure();
    test_random_settings();
    test_streaming();

    drain();
    if (carrier_q.size() != 0) begin
      errors += carrier_q.size();
      $display("%0t: %0d expected carriers never came out", $time, carrier_q.size());
    end
    $display("Sent %0d coded bits, checked %0d carriers and %0d symbol ends",
             bits_sent, carriers_checked, symbols_closed);
    $display("across all modulations and layouts, mid-group switches and back-pressure.");
    if (errors == 0) begin
      $display("tb_ofdm_qam_subcarrier_mapper: done, clean");
    end else begin
      $display("tb_ofdm_qam_subcarrier_mapper: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
